// File: design/frga_pkg.sv
// Package: glyph range tables and shared types for the font ROM glyph address block.
package frga_pkg;

  localparam int unsigned CpWidth     = 16;
  localparam int unsigned AddrWidth   = 17;
  localparam int unsigned SlotWidth   = 10;
  localparam int unsigned NarrowCount = 11;
  localparam int unsigned WideCount   = 12;

  typedef struct packed {
    logic [CpWidth-1:0]   lo;
    logic [CpWidth-1:0]   hi;
    logic [SlotWidth-1:0] slot;
    logic [AddrWidth-1:0] base;
  } glyph_range_t;

  typedef struct packed {
    logic                 hit;
    logic [AddrWidth-1:0] addr;
  } lookup_res_t;

  // 8x16 table, 16 bytes per glyph
  localparam glyph_range_t NARROW_TABLE [NarrowCount] = '{
    '{16'h0020, 16'h007F, 10'd0,   17'd25280},
    '{16'h00A0, 16'h017F, 10'd96,  17'd25280},
    '{16'h01A0, 16'h01CF, 10'd320, 17'd25280},
    '{16'h01F0, 16'h01FF, 10'd368, 17'd25280},
    '{16'h0210, 16'h021F, 10'd384, 17'd25280},
    '{16'h1EA0, 16'h1EFF, 10'd400, 17'd25280},
    '{16'h0370, 16'h03CF, 10'd0,   17'd33216},
    '{16'h0400, 16'h045F, 10'd0,   17'd34752},
    '{16'h0490, 16'h04FF, 10'd96,  17'd34752},
    '{16'h0590, 16'h05FF, 10'd0,   17'd38080},
    '{16'h0E00, 16'h0E5F, 10'd0,   17'd39872}
  };

  // variable-width 16-pixel table, 34 bytes per glyph
  localparam glyph_range_t WIDE_TABLE [WideCount] = '{
    '{16'h0600, 16'h06FF, 10'd0,   17'd80320},
    '{16'hFB50, 16'hFBFF, 10'd256, 17'd80320},
    '{16'hFE70, 16'hFEFF, 10'd432, 17'd80320},
    '{16'h0020, 16'h007F, 10'd0,   17'd99904},
    '{16'h00A0, 16'h017F, 10'd96,  17'd99904},
    '{16'h01A0, 16'h01CF, 10'd320, 17'd99904},
    '{16'h01F0, 16'h01FF, 10'd368, 17'd99904},
    '{16'h0210, 16'h021F, 10'd384, 17'd99904},
    '{16'h1EA0, 16'h1EFF, 10'd400, 17'd99904},
    '{16'h0370, 16'h03CF, 10'd0,   17'd116768},
    '{16'h0400, 16'h045F, 10'd0,   17'd120032},
    '{16'h0490, 16'h04FF, 10'd96,  17'd120032}
  };

endpackage

// File: design/frga_lookup.sv
// Range match and glyph address computation for one code point.
module frga_lookup (
  input  logic [frga_pkg::CpWidth-1:0] code_point,
  input  logic                         narrow_only_mode,
  output frga_pkg::lookup_res_t        res
);

  logic                              narrow_sel;
  logic                              n_hit;
  logic                              w_hit;
  logic [frga_pkg::AddrWidth-1:0]    n_off;
  logic [frga_pkg::AddrWidth-1:0]    w_off;
  logic [frga_pkg::AddrWidth-1:0]    n_base;
  logic [frga_pkg::AddrWidth-1:0]    w_base;
  logic [frga_pkg::AddrWidth-1:0]    n_addr;
  logic [frga_pkg::AddrWidth-1:0]    w_addr;

  assign narrow_sel = (code_point[15:8] == 8'd0) || narrow_only_mode;

  always_comb begin
    n_hit  = 1'b0;
    n_off  = '0;
    n_base = '0;
    for (int k = 0; k < frga_pkg::NarrowCount; k++) begin
      if (!n_hit && code_point >= frga_pkg::NARROW_TABLE[k].lo &&
          code_point <= frga_pkg::NARROW_TABLE[k].hi) begin
        n_hit  = 1'b1;
        n_off  = {1'b0, code_point - frga_pkg::NARROW_TABLE[k].lo}
               + {7'd0, frga_pkg::NARROW_TABLE[k].slot};
        n_base = frga_pkg::NARROW_TABLE[k].base;
      end
    end
  end

  always_comb begin
    w_hit  = 1'b0;
    w_off  = '0;
    w_base = '0;
    for (int k = 0; k < frga_pkg::WideCount; k++) begin
      if (!w_hit && code_point >= frga_pkg::WIDE_TABLE[k].lo &&
          code_point <= frga_pkg::WIDE_TABLE[k].hi) begin
        w_hit  = 1'b1;
        w_off  = {1'b0, code_point - frga_pkg::WIDE_TABLE[k].lo}
               + {7'd0, frga_pkg::WIDE_TABLE[k].slot};
        w_base = frga_pkg::WIDE_TABLE[k].base;
      end
    end
  end

  // x16 and x34 as shifts and adds
  assign n_addr = (n_off << 4) + n_base;
  assign w_addr = (w_off << 5) + (w_off << 1) + w_base;

  always_comb begin
    if (narrow_sel) begin
      res.hit  = n_hit;
      res.addr = n_addr;
    end else begin
      res.hit  = w_hit;
      res.addr = w_addr;
    end
  end

endmodule

// File: design/font_rom_glyph_address.sv
// Top level: font ROM glyph address generator with input and result registers.
// Each input beat carries one UCS-2 code point and gives one result beat with the glyph's
// byte address in the font ROM and a matched flag. An input register feeds one short range
// match and shift-add stage into the result register, so a beat is taken every cycle and its
// result beat is presented from the result register; the result register stalls the input
// side only while a result waits for out_tready. Unmatched characters repeat the previous
// address; the held address returns to 0 after a beat with in_tlast set.
module font_rom_glyph_address (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_point
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] glyph_address, [23:17] zero
  output logic [0:0]  out_tuser,  // [0] matched
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // [0] narrow_only_mode
);

  logic                              in_valid_r;
  logic [frga_pkg::CpWidth-1:0]      cp_r;
  logic                              last_r;
  logic                              out_valid_r;
  logic [frga_pkg::AddrWidth-1:0]    out_addr_r;
  logic                              out_hit_r;
  logic [frga_pkg::AddrWidth-1:0]    held_r;
  logic [frga_pkg::AddrWidth-1:0]    held_nxt;
  logic                              mode_r;
  logic                              advance;
  frga_pkg::lookup_res_t             res;

  frga_lookup u_lookup (
    .code_point       (cp_r),
    .narrow_only_mode (mode_r),
    .res              (res)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    held_nxt = res.hit ? res.addr : held_r;
    if (last_r) begin
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      mode_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data[0];
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        held_r      <= held_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cp_r   <= in_tdata;
      last_r <= in_tlast;
    end
    if (advance) begin
      out_addr_r <= res.hit ? res.addr : held_r;
      out_hit_r  <= res.hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_addr_r};
  assign out_tuser  = out_hit_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_r |=> held_r == '0)
    else $error("held address not cleared after last beat");

  a_miss_repeats: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !res.hit |=> out_addr_r == $past(held_r) && !out_hit_r)
    else $error("unmatched beat did not repeat held address");

  a_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.hit && !last_r |=> held_r == out_addr_r)
    else $error("held address differs from matched result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> held_r == '0 && !out_valid_r && !in_valid_r)
    else $error("state not cleared by reset");

endmodule

// File: tb/sv/glyph_address_monitor.sv
// Monitor: predicts glyph addresses from input beats and checks the result beats.
module glyph_address_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_point
  input  logic        in_tlast,   // last_char
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [16:0] glyph_address, [23:17] zero
  input  logic [0:0]  out_tuser,  // [0] matched
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_data,   // [0] narrow_only_mode
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NarrowBytes = 16;
  localparam int unsigned WideBytes   = 34;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] final_cp;
    logic [9:0]  slot;
    logic [16:0] base;
  } span_t;

  typedef struct packed {
    logic [16:0] addr;
    logic        hit;
  } glyph_t;

  localparam span_t NARROW_SPANS [11] = '{
    '{16'h0020, 16'h007F, 10'd0,   17'd25280},
    '{16'h00A0, 16'h017F, 10'd96,  17'd25280},
    '{16'h01A0, 16'h01CF, 10'd320, 17'd25280},
    '{16'h01F0, 16'h01FF, 10'd368, 17'd25280},
    '{16'h0210, 16'h021F, 10'd384, 17'd25280},
    '{16'h1EA0, 16'h1EFF, 10'd400, 17'd25280},
    '{16'h0370, 16'h03CF, 10'd0,   17'd33216},
    '{16'h0400, 16'h045F, 10'd0,   17'd34752},
    '{16'h0490, 16'h04FF, 10'd96,  17'd34752},
    '{16'h0590, 16'h05FF, 10'd0,   17'd38080},
    '{16'h0E00, 16'h0E5F, 10'd0,   17'd39872}
  };

  localparam span_t WIDE_SPANS [12] = '{
    '{16'h0600, 16'h06FF, 10'd0,   17'd80320},
    '{16'hFB50, 16'hFBFF, 10'd256, 17'd80320},
    '{16'hFE70, 16'hFEFF, 10'd432, 17'd80320},
    '{16'h0020, 16'h007F, 10'd0,   17'd99904},
    '{16'h00A0, 16'h017F, 10'd96,  17'd99904},
    '{16'h01A0, 16'h01CF, 10'd320, 17'd99904},
    '{16'h01F0, 16'h01FF, 10'd368, 17'd99904},
    '{16'h0210, 16'h021F, 10'd384, 17'd99904},
    '{16'h1EA0, 16'h1EFF, 10'd400, 17'd99904},
    '{16'h0370, 16'h03CF, 10'd0,   17'd116768},
    '{16'h0400, 16'h045F, 10'd0,   17'd120032},
    '{16'h0490, 16'h04FF, 10'd96,  17'd120032}
  };

  logic        narrow_mode;
  logic [16:0] held_addr;
  glyph_t      pending_glyphs [$];

  function automatic glyph_t glyph_lookup(input logic [15:0] cp, input logic use_narrow);
    glyph_t      g;
    span_t       s;
    int unsigned a;
    g = '0;
    if (use_narrow) begin
      for (int i = 0; i < 11; i++) begin
        s = NARROW_SPANS[i];
        if (!g.hit && cp >= s.first && cp <= s.final_cp) begin
          a = (32'(cp) - 32'(s.first) + 32'(s.slot)) * NarrowBytes + 32'(s.base);
          g.hit  = 1'b1;
          g.addr = a[16:0];
        end
      end
    end else begin
      for (int i = 0; i < 12; i++) begin
        s = WIDE_SPANS[i];
        if (!g.hit && cp >= s.first && cp <= s.final_cp) begin
          a = (32'(cp) - 32'(s.first) + 32'(s.slot)) * WideBytes + 32'(s.base);
          g.hit  = 1'b1;
          g.addr = a[16:0];
        end
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    glyph_t want;
    int     bad;
    bad = 0;
    if (!rst_n) begin
      narrow_mode <= 1'b0;
      held_addr   <= '0;
      pending_glyphs.delete();
      pending     <= 0;
      errors      <= 0;
    end else begin
      if (cfg_valid && cfg_ready) narrow_mode <= cfg_data[0];

      if (out_tvalid && out_tready) begin
        if (pending_glyphs.size() == 0) begin
          bad++;
          $display("%0t: unexpected result beat addr=%0d matched=%0b", $time,
                   out_tdata[16:0], out_tuser[0]);
        end else begin
          want = pending_glyphs.pop_front();
          if (out_tdata[16:0] != want.addr) begin
            bad++;
            $display("%0t: glyph_address expected %0d actual %0d", $time, want.addr,
                     out_tdata[16:0]);
          end
          if (out_tuser[0] != want.hit) begin
            bad++;
            $display("%0t: matched expected %0b actual %0b", $time, want.hit, out_tuser[0]);
          end
          if (out_tdata[23:17] != 7'd0) begin
            bad++;
            $display("%0t: tdata pad expected 0 actual %0h", $time, out_tdata[23:17]);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        want = glyph_lookup(in_tdata, in_tdata[15:8] == 8'd0 || narrow_mode);
        // miss repeats the held address; end of string clears it afterwards
        if (!want.hit) want.addr = held_addr;
        held_addr <= in_tlast ? 17'd0 : want.addr;
        pending_glyphs.push_back(want);
      end

      pending <= pending_glyphs.size();
      errors  <= errors + bad;
    end
  end

endmodule

// File: tb/sv/font_rom_glyph_address_tb.sv
// Testbench top: drives code point strings and mode writes into the glyph address block.
module font_rom_glyph_address_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [15:0] code_point
  logic        in_tlast   = 1'b0; // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [16:0] glyph_address, [23:17] zero
  logic [0:0]  out_tuser;         // [0] matched
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data   = '0;   // [0] narrow_only_mode
  logic        calm       = 1'b0;
  int          pending;
  int          errors;

  // lo/hi of every range in either table
  localparam logic [31:0] KNOWN_SPANS [14] = '{
    {16'h0020, 16'h007F}, {16'h00A0, 16'h017F}, {16'h01A0, 16'h01CF},
    {16'h01F0, 16'h01FF}, {16'h0210, 16'h021F}, {16'h1EA0, 16'h1EFF},
    {16'h0370, 16'h03CF}, {16'h0400, 16'h045F}, {16'h0490, 16'h04FF},
    {16'h0590, 16'h05FF}, {16'h0E00, 16'h0E5F}, {16'h0600, 16'h06FF},
    {16'hFB50, 16'hFBFF}, {16'hFE70, 16'hFEFF}
  };

  font_rom_glyph_address u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  glyph_address_monitor u_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 9);
  end

  initial begin
    #200us;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_char(input logic [15:0] cp, input logic last);
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cp;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic narrow);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= narrow;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_code();
    int unsigned r;
    logic [31:0] span;
    r    = $urandom_range(99);
    span = KNOWN_SPANS[$urandom_range(13)];
    if (r < 45) return 16'($urandom_range(span[15:0], span[31:16]));
    if (r < 65) begin
      case ($urandom_range(3))
        0:       return span[31:16] - 16'd1;
        1:       return span[31:16];
        2:       return span[15:0];
        default: return span[15:0] + 16'd1;
      endcase
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  initial begin : stim
    int unsigned left;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(1'b0);
    send_char(16'h0041, 1'b0);
    send_char(16'h0000, 1'b0);  // miss repeats previous address
    send_char(16'h0020, 1'b0);
    send_char(16'h007F, 1'b0);
    send_char(16'h0080, 1'b0);
    send_char(16'h00A0, 1'b0);
    send_char(16'h017F, 1'b1);
    send_char(16'h0180, 1'b0);  // miss right after end of string
    send_char(16'h1EA0, 1'b0);
    send_char(16'h1EFF, 1'b0);
    send_char(16'h0590, 1'b0);  // no Hebrew in wide table
    send_char(16'h0E00, 1'b0);  // no Thai in wide table
    send_char(16'h0370, 1'b0);
    send_char(16'h0400, 1'b0);
    send_char(16'h04FF, 1'b0);
    send_char(16'h0600, 1'b0);
    send_char(16'h06FF, 1'b0);
    send_char(16'hFB50, 1'b0);
    send_char(16'hFE70, 1'b0);
    send_char(16'hFFFF, 1'b1);

    write_mode(1'b1);
    send_char(16'h0600, 1'b0);
    send_char(16'h1EA0, 1'b0);
    send_char(16'h0590, 1'b0);
    send_char(16'h05FF, 1'b0);
    send_char(16'h0E5F, 1'b0);
    send_char(16'hFEFF, 1'b0);
    send_char(16'h0041, 1'b1);

    for (int chunk = 0; chunk < 5; chunk++) begin
      write_mode(chunk == 4 ? 1'($urandom_range(1)) : 1'(chunk % 2));
      calm <= (chunk == 2);
      for (int i = 0; i < 130; i++) begin
        if (chunk == 3 && i == 65) wait_drained();
        // mostly strings of 1..8 characters closed by last_char, some stray flags
        if (i % 8 == 0) left = $urandom_range(8, 1);
        left = left - 1;
        send_char(pick_code(), left == 0 ? 1'b1 : 1'($urandom_range(19) == 0));
        if (left == 0) left = $urandom_range(8, 1);
      end
      calm <= 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
